>>> design/dmx_pkg.sv
// shared types and constants of the dmx512 frame engine
package dmx_pkg;

    // slot buffer geometry
    localparam int SLOT_COUNT     = 512;
    localparam int MIN_SLOT_COUNT = 24;
    localparam int BUF_DEPTH      = SLOT_COUNT + 1;
    localparam int BUF_AW         = $clog2(BUF_DEPTH);
    localparam int SLOT_W         = 10;
    localparam int BYTE_W         = 8;
    localparam int ACT_W          = 4;

    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] SLOT_MIN = SLOT_W'(MIN_SLOT_COUNT);

    // register indexes of the configuration port
    localparam logic REG_MAX_SLOTS = 1'b0;

    // event codes carried in the input word
    typedef enum logic [ACT_W-1:0] {
        ACT_START_OUTPUT = 4'd0,
        ACT_START_INPUT  = 4'd1,
        ACT_TX_EMPTY     = 4'd2,
        ACT_TX_COMPLETE  = 4'd3,
        ACT_RX_BYTE      = 4'd4,
        ACT_FRAMING_ERR  = 4'd5,
        ACT_HOST_WRITE   = 4'd6,
        ACT_HOST_READ    = 4'd7,
        ACT_STOP         = 4'd8
    } t_action;

    // frame sequencing phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_START = 2'd2,
        PH_DATA  = 2'd3
    } t_phase;

    // run direction
    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_OUT = 2'd1,
        MODE_IN  = 2'd2
    } t_mode;

endpackage

>>> design/dmx512_frame_engine.sv
// dmx512 frame engine: event-driven frame sequencer with a 513-byte slot buffer
//
// Each input word carries one UART or host event and yields exactly one result
// word. A word is accepted every cycle while the result side does not stall;
// its result passes through stage one (state update and slot buffer access) and
// then the output register. All control decisions are made at accept time; the
// slot buffer is one ram with one write and one registered read port, so any
// event touches it at most once. After reset a clearing pass zeroes all 513
// slot buffer entries, during which s_tready stays low; configuration writes
// are taken at any time. max_slots is clamped to 24..512 when used.
module dmx512_frame_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] rx_data, [17:8] slot_index, [25:18] write_value, zero above
    input  logic [31:0] s_tdata,
    // [3:0] action
    input  logic [3:0]  s_tuser,
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] break_baud, [10] wait_complete,
    // [11] frame_done, [21:12] frame_slots, [29:22] read_value, zero above
    output logic [31:0] m_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dmx_pkg::*;

    // configuration register
    logic [SLOT_W-1:0] r_max_slots;
    logic [SLOT_W-1:0] w_eff_max;

    // control state
    t_phase            r_phase, n_phase;
    t_mode             r_mode, n_mode;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_wait, n_wait;
    logic              r_brk, n_brk;

    // clearing pass
    logic              r_clr_active;
    logic [BUF_AW-1:0] r_clr_addr;

    // stage one result
    logic              r_s1_valid;
    logic              r_s1_txv, n_s1_txv;
    logic              r_s1_txmem, n_s1_txmem;
    logic              r_s1_done, n_s1_done;
    logic [SLOT_W-1:0] r_s1_slots, n_s1_slots;
    logic              r_s1_rdmem, n_s1_rdmem;
    logic              r_s1_brk;
    logic              r_s1_wait;

    // output register
    logic              r_out_valid;
    logic [29:0]       r_out_data;

    // input word fields
    logic [ACT_W-1:0]  w_action;
    logic [BYTE_W-1:0] w_rx;
    logic [SLOT_W-1:0] w_idx;
    logic [BYTE_W-1:0] w_wv;
    logic              w_idx_ok;

    // handshake and ram control
    logic              w_accept;
    logic              w_out_free;
    logic              w_s1_move;
    logic              n_we;
    logic [BUF_AW-1:0] n_waddr;
    logic [BYTE_W-1:0] n_wdata;
    logic              n_re;
    logic [BUF_AW-1:0] n_raddr;
    logic [BYTE_W-1:0] w_rdata;
    logic [SLOT_W-1:0] w_slot_inc;
    logic              w_cfg_wr;

    assign w_action = s_tuser;
    assign w_rx     = s_tdata[7:0];
    assign w_idx    = s_tdata[17:8];
    assign w_wv     = s_tdata[25:18];
    assign w_idx_ok = (w_idx <= SLOT_MAX);

    // handshake
    assign w_out_free = !r_out_valid || m_tready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign s_tready   = !r_clr_active && (!r_s1_valid || w_out_free);
    assign w_accept   = s_tvalid && s_tready;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_MAX_SLOTS) ? {22'd0, r_max_slots} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_slots <= SLOT_MAX;
        end else if (w_cfg_wr && paddr[2] == REG_MAX_SLOTS) begin
            r_max_slots <= pwdata[SLOT_W-1:0];
        end
    end

    // clamp of the slot limit
    always_comb begin
        if (r_max_slots < SLOT_MIN) begin
            w_eff_max = SLOT_MIN;
        end else if (r_max_slots > SLOT_MAX) begin
            w_eff_max = SLOT_MAX;
        end else begin
            w_eff_max = r_max_slots;
        end
    end

    assign w_slot_inc = r_slot + SLOT_W'(1);

    // next state, buffer access and step result
    always_comb begin
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_slot     = r_slot;
        n_wait     = r_wait;
        n_brk      = r_brk;
        n_s1_txv   = 1'b0;
        n_s1_txmem = 1'b0;
        n_s1_done  = 1'b0;
        n_s1_slots = '0;
        n_s1_rdmem = 1'b0;
        n_we       = 1'b0;
        n_waddr    = r_slot[BUF_AW-1:0];
        n_wdata    = w_rx;
        n_re       = 1'b0;
        n_raddr    = r_slot[BUF_AW-1:0];
        case (t_action'(w_action))
            ACT_START_OUTPUT: begin
                if (r_mode != MODE_OUT) begin
                    n_brk    = 1'b1;
                    n_slot   = '0;
                    n_phase  = PH_BREAK;
                    n_mode   = MODE_OUT;
                    n_s1_txv = 1'b1;
                    n_wait   = 1'b1;
                end
            end
            ACT_START_INPUT: begin
                if (r_mode != MODE_IN) begin
                    n_slot  = '0;
                    n_phase = PH_IDLE;
                    n_brk   = 1'b0;
                    n_wait  = 1'b0;
                    n_mode  = MODE_IN;
                end
            end
            ACT_TX_EMPTY: begin
                if (r_mode == MODE_OUT && !r_wait) begin
                    case (r_phase)
                        PH_DATA: begin
                            n_s1_txv   = 1'b1;
                            n_s1_txmem = 1'b1;
                            n_re       = 1'b1;
                            n_slot     = w_slot_inc;
                            if (w_slot_inc > w_eff_max) begin
                                n_phase = PH_IDLE;
                                n_wait  = 1'b1;
                            end
                        end
                        PH_BREAK: begin
                            n_wait   = 1'b1;
                            n_s1_txv = 1'b1;
                        end
                        PH_START: begin
                            n_s1_txv = 1'b1;
                            n_phase  = PH_DATA;
                            n_slot   = SLOT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ACT_TX_COMPLETE: begin
                if (r_mode == MODE_OUT && r_wait) begin
                    case (r_phase)
                        PH_IDLE: begin
                            n_brk   = 1'b1;
                            n_phase = PH_BREAK;
                            n_wait  = 1'b0;
                        end
                        PH_BREAK: begin
                            n_brk   = 1'b0;
                            n_phase = PH_START;
                            n_wait  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ACT_RX_BYTE: begin
                if (r_mode == MODE_IN) begin
                    case (r_phase)
                        PH_BREAK: begin
                            // zero start code opens a frame, others idle
                            if (w_rx == '0) begin
                                n_we    = (r_slot <= SLOT_MAX);
                                n_phase = PH_DATA;
                                n_slot  = SLOT_W'(1);
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_DATA: begin
                            n_we   = (r_slot <= SLOT_MAX);
                            n_slot = w_slot_inc;
                            if (w_slot_inc > SLOT_MAX) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ACT_FRAMING_ERR: begin
                if (r_mode == MODE_IN) begin
                    n_phase = PH_BREAK;
                    if (r_slot != '0) begin
                        n_s1_done  = 1'b1;
                        n_s1_slots = r_slot;
                    end
                    n_slot = '0;
                end
            end
            ACT_HOST_WRITE: begin
                n_we    = w_idx_ok;
                n_waddr = w_idx[BUF_AW-1:0];
                n_wdata = w_wv;
            end
            ACT_HOST_READ: begin
                n_re       = w_idx_ok;
                n_raddr    = w_idx[BUF_AW-1:0];
                n_s1_rdmem = w_idx_ok;
            end
            ACT_STOP: begin
                n_mode = MODE_OFF;
            end
            default: begin
            end
        endcase
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mode  <= MODE_OFF;
            r_slot  <= '0;
            r_wait  <= 1'b0;
            r_brk   <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_slot  <= n_slot;
            r_wait  <= n_wait;
            r_brk   <= n_brk;
        end
    end

    // clearing pass over the slot buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + BUF_AW'(1);
            if (r_clr_addr == BUF_AW'(BUF_DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // slot buffer
    dmx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_slot_buf (
        .i_clk   (i_clk),
        .i_we    (r_clr_active || (w_accept && n_we)),
        .i_waddr (r_clr_active ? r_clr_addr : n_waddr),
        .i_wdata (r_clr_active ? '0 : n_wdata),
        .i_re    (w_accept && n_re),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    // stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_txv   <= n_s1_txv;
            r_s1_txmem <= n_s1_txmem;
            r_s1_done  <= n_s1_done;
            r_s1_slots <= n_s1_slots;
            r_s1_rdmem <= n_s1_rdmem;
            r_s1_brk   <= n_brk;
            r_s1_wait  <= n_wait;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data <= {
                r_s1_rdmem ? w_rdata : 8'd0,
                r_s1_slots,
                r_s1_done,
                r_s1_wait,
                r_s1_brk,
                r_s1_txmem ? w_rdata : 8'd0,
                r_s1_txv
            };
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out_data};

endmodule

>>> design/dmx_ram.sv
// generic single write port ram with registered read
module dmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 513
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
